@@ sv/mrmt_pkg.sv @@
// Package for the memory region map table: sizes, operation and status codes,
// the stored entry layout and the controller state encoding.
// Depends on nothing; every module of the block imports it.
package mrmt_pkg;

    // Table depth and the widths that follow from it.
    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths of the stream words.
    localparam int ADDR_W     = 64;
    localparam int RTYPE_W    = 32;
    localparam int NIDX_W     = 5;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int FIG_W      = 6;
    localparam int RB_W       = 8;
    localparam int S_TDATA_W  = 232;
    localparam int M_TDATA_W  = 304;

    localparam logic [RB_W-1:0]    RECORD_BYTES_RST = 8'd24;
    localparam logic [RTYPE_W-1:0] TYPE_USABLE      = 32'd1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_QUERY  = 2'd1,
        OP_SELECT = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // One stored region.
    typedef struct packed {
        logic [RTYPE_W-1:0] rtype;
        logic [ADDR_W-1:0]  length;
        logic [ADDR_W-1:0]  base;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

endpackage

@@ sv/memory_region_map_table_core.sv @@
// Top level of the memory region map table: region store, running figures,
// scan sequencer and output register. Depends on mrmt_pkg.
// A load or a clear goes straight to the finish state; a query or a select first walks
// the regions one per cycle until a hit or the end of the table. The finish state loads
// the result register once it is free (m_tvalid low or m_tready high), then goes idle.
// One word at a time: the next input word is taken in the cycle after the result
// register is loaded, later while the finish state waits on m_tready.
// Reset clears the figures and the entry count and sets record_bytes to 24; not the memory.
module memory_region_map_table_core
    import mrmt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration: record_bytes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [RB_W-1:0]      cfg_data,

    // Input words.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0 up: region_base[63:0], region_length[127:64],
    // region_type[159:128], query_address[223:160], unusable_index[228:224],
    // zero fill[231:229].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0 up: operation[1:0].
    input  logic [OP_W-1:0]      s_tuser,

    // Result words.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0 up: out_base[63:0], out_length[127:64],
    // out_type[159:128], usable_total[223:160], total_size[287:224],
    // unusable_count[293:288], entries_used[299:294], zero fill[303:300].
    output logic [M_TDATA_W-1:0] m_tdata,
    // Fields from bit 0 up: status[1:0].
    output logic [STATUS_W-1:0]  m_tuser
);

    // Input word fields.
    logic [ADDR_W-1:0]  in_base;
    logic [ADDR_W-1:0]  in_length;
    logic [RTYPE_W-1:0] in_rtype;
    logic [ADDR_W-1:0]  in_qaddr;
    logic [NIDX_W-1:0]  in_nidx;
    op_t                in_op;

    assign in_base   = s_tdata[63:0];
    assign in_length = s_tdata[127:64];
    assign in_rtype  = s_tdata[159:128];
    assign in_qaddr  = s_tdata[223:160];
    assign in_nidx   = s_tdata[228:224];
    assign in_op     = op_t'(s_tuser);

    // Controller and figure registers.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   unusable_reg, unusable_next;
    logic [ADDR_W-1:0]  usable_sum_reg, usable_sum_next;
    logic [ADDR_W-1:0]  size_sum_reg, size_sum_next;
    logic [RB_W-1:0]    record_bytes_reg, record_bytes_next;

    // Per-operation working registers.
    op_t                op_reg, op_next;
    logic [ADDR_W-1:0]  qaddr_reg, qaddr_next;
    logic [NIDX_W-1:0]  left_reg, left_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               chk_valid_reg, chk_valid_next;
    status_t            status_reg, status_next;
    entry_t             sel_entry_reg, sel_entry_next;

    // Output register.
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]  m_tuser_reg, m_tuser_next;

    // Region memory: one write port, one registered read port.
    entry_t             mem [MAX_ENTRIES];
    entry_t             rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;

    logic               in_accept;
    logic               table_full;

    // Scan evaluation of the entry that came out of the memory this cycle.
    logic [ADDR_W:0]    region_end;
    logic               addr_inside;
    logic               entry_usable;
    logic               hit_query;
    logic               hit_select;
    logic               scan_exhausted;

    // Reported usable total.
    logic [CNT_W+RB_W-1:0] deduct;
    logic [ADDR_W-1:0]     deduct_wide;
    logic [ADDR_W-1:0]     usable_total;

    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == S_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign table_full = (count_reg >= CNT_W'(MAX_ENTRIES));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Loads write at the slot after the last entry, and walks only start once
    // the load is finished, so a read never meets a write to the same entry.
    assign mem_we    = in_accept && (in_op == OP_LOAD) && !table_full;
    assign mem_waddr = count_reg[IDX_W-1:0];
    assign mem_wdata = '{rtype: in_rtype, length: in_length, base: in_base};
    assign mem_raddr = issue_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // The end of a region is taken 65 bits wide so that a region reaching the
    // top of the address space still covers its last byte.
    assign region_end     = {1'b0, rd_data_reg.base} + {1'b0, rd_data_reg.length};
    assign addr_inside    = (qaddr_reg >= rd_data_reg.base) &&
                            ({1'b0, qaddr_reg} < region_end);
    assign entry_usable   = (rd_data_reg.rtype == TYPE_USABLE);
    assign hit_query      = chk_valid_reg && (op_reg == OP_QUERY) &&
                            entry_usable && addr_inside;
    assign hit_select     = chk_valid_reg && (op_reg == OP_SELECT) &&
                            !entry_usable && (left_reg == '0);
    assign scan_exhausted = !chk_valid_reg && (issue_reg >= count_reg);

    // Every stored record costs record_bytes of the usable total.
    assign deduct       = {{RB_W{1'b0}}, count_reg} * {{CNT_W{1'b0}}, record_bytes_reg};
    assign deduct_wide  = ADDR_W'(deduct);
    assign usable_total = (usable_sum_reg > deduct_wide) ?
                          (usable_sum_reg - deduct_wide) : '0;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        unusable_next     = unusable_reg;
        usable_sum_next   = usable_sum_reg;
        size_sum_next     = size_sum_reg;
        record_bytes_next = record_bytes_reg;
        op_next           = op_reg;
        qaddr_next        = qaddr_reg;
        left_next         = left_reg;
        issue_next        = issue_reg;
        chk_valid_next    = 1'b0;
        status_next       = status_reg;
        sel_entry_next    = sel_entry_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;

        if (cfg_valid && cfg_ready)
        begin
            record_bytes_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next        = in_op;
                    qaddr_next     = in_qaddr;
                    left_next      = in_nidx;
                    issue_next     = '0;
                    sel_entry_next = '0;
                    status_next    = ST_OK;
                    case (in_op)
                        OP_LOAD:
                        begin
                            state_next = S_FIN;
                            if (table_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next    = count_reg + CNT_W'(1);
                                size_sum_next = size_sum_reg + in_length;
                                if (in_rtype != TYPE_USABLE)
                                begin
                                    unusable_next = unusable_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    // A zero length adds nothing either way.
                                    usable_sum_next = usable_sum_reg + in_length;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            state_next      = S_FIN;
                            count_next      = '0;
                            unusable_next   = '0;
                            usable_sum_next = '0;
                            size_sum_next   = '0;
                        end
                        default:
                        begin
                            state_next  = S_SCAN;
                            status_next = ST_MISS;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue the next read while the previous entry is checked.
                if (issue_reg < count_reg)
                begin
                    issue_next     = issue_reg + CNT_W'(1);
                    chk_valid_next = 1'b1;
                end
                if (chk_valid_reg && (op_reg == OP_SELECT) && !entry_usable)
                begin
                    left_next = left_reg - NIDX_W'(1);
                end
                if (hit_query)
                begin
                    status_next = ST_OK;
                    state_next  = S_FIN;
                end
                else if (hit_select)
                begin
                    status_next    = ST_OK;
                    sel_entry_next = rd_data_reg;
                    state_next     = S_FIN;
                end
                else if (scan_exhausted)
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = {4'b0000,
                                     FIG_W'(count_reg),
                                     FIG_W'(unusable_reg),
                                     size_sum_reg,
                                     usable_total,
                                     sel_entry_reg.rtype,
                                     sel_entry_reg.length,
                                     sel_entry_reg.base};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            unusable_reg     <= '0;
            usable_sum_reg   <= '0;
            size_sum_reg     <= '0;
            record_bytes_reg <= RECORD_BYTES_RST;
            op_reg           <= OP_LOAD;
            qaddr_reg        <= '0;
            left_reg         <= '0;
            issue_reg        <= '0;
            chk_valid_reg    <= 1'b0;
            status_reg       <= ST_OK;
            sel_entry_reg    <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
            m_tuser_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            unusable_reg     <= unusable_next;
            usable_sum_reg   <= usable_sum_next;
            size_sum_reg     <= size_sum_next;
            record_bytes_reg <= record_bytes_next;
            op_reg           <= op_next;
            qaddr_reg        <= qaddr_next;
            left_reg         <= left_next;
            issue_reg        <= issue_next;
            chk_valid_reg    <= chk_valid_next;
            status_reg       <= status_next;
            sel_entry_reg    <= sel_entry_next;
            m_tvalid_reg     <= m_tvalid_next;
            m_tdata_reg      <= m_tdata_next;
            m_tuser_reg      <= m_tuser_next;
        end
    end

`ifndef ASSERT_OFF
    // Unusable regions are a subset of the stored ones.
    a_unusable_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        unusable_reg <= count_reg)
        else $error("unusable tally exceeds entry count");

    // A load into a full table leaves the entry count as it was.
    a_full_load_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_op == OP_LOAD) && table_full) |=> $stable(count_reg))
        else $error("load into full table changed the entry count");

    // A clear empties the count and the figures.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_op == OP_CLEAR)) |=>
        ((count_reg == '0) && (size_sum_reg == '0) && (usable_sum_reg == '0)))
        else $error("clear left figures behind");

    // The walk never reads past the stored entries.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_reg <= count_reg))
        else $error("scan index ran past the entry count");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for memory_region_map_table_core: a queued stream driver,
// a result monitor backed by a region table predictor, and a watchdog.
// Depends on mrmt_pkg and the core RTL; reads no files.
module testbench;
    import mrmt_pkg::*;

    // A run of this many cycles with no handshake on any channel ends the run.
    // The longest correct quiet stretch is the receiver hold below plus a scan.
    localparam int WATCHDOG_LIMIT = 2000;
    // The receiver stops taking result words for a long stretch once, after
    // this many results, so that the output register fills and s_tready drops.
    localparam int HOLD_AT_RESULT = 150;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_WORDS    = 230;
    localparam int SETTLE_CYCLES  = 40;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    // One input word as the sender sees it, plus the pause after it is taken.
    typedef struct {
        op_t                op;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  length;
        logic [RTYPE_W-1:0] rtype;
        logic [ADDR_W-1:0]  addr;
        logic [NIDX_W-1:0]  nidx;
        int unsigned        idle_after;
    } map_word_t;

    // One result word, field by field.
    typedef struct {
        status_t            status;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  length;
        logic [RTYPE_W-1:0] rtype;
        logic [ADDR_W-1:0]  usable_total;
        logic [ADDR_W-1:0]  total_size;
        logic [FIG_W-1:0]   unusable_count;
        logic [FIG_W-1:0]   entries_used;
    } map_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [RB_W-1:0]      cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // Fields from bit 0 up: region_base, region_length, region_type,
    // query_address, unusable_index, zero fill.
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    // Fields from bit 0 up: operation.
    logic [OP_W-1:0]      s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // Fields from bit 0 up: out_base, out_length, out_type, usable_total,
    // total_size, unusable_count, entries_used, zero fill.
    logic [M_TDATA_W-1:0] m_tdata;
    // Fields from bit 0 up: status.
    logic [STATUS_W-1:0]  m_tuser;

    // Words waiting to be offered, and results waiting to be seen.
    map_word_t   pending_words[$];
    map_result_t expected_results[$];
    int unsigned words_queued = 0;
    int          mismatches   = 0;

    // Predicted state of the region table and its running figures.
    logic [ADDR_W-1:0]  tab_base   [MAX_ENTRIES];
    logic [ADDR_W-1:0]  tab_length [MAX_ENTRIES];
    logic [RTYPE_W-1:0] tab_type   [MAX_ENTRIES];
    int unsigned        tab_entries      = 0;
    logic [ADDR_W-1:0]  usable_bytes     = '0;
    logic [ADDR_W-1:0]  size_bytes       = '0;
    int unsigned        unusable_regions = 0;
    logic [RB_W-1:0]    record_bytes     = RECORD_BYTES_RST;

    // Driver and monitor bookkeeping.
    map_word_t   offered_word;
    logic        send_next;
    int unsigned send_idle    = 0;
    int unsigned results_seen = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;
    int unsigned calm_left    = 0;
    int unsigned quiet_cycles = 0;

    memory_region_map_table_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // Applies one accepted word to the predicted table and returns the result
    // word that it must produce. Every word gives exactly one result.
    function automatic map_result_t region_map_result(map_word_t w);
        map_result_t     r;
        logic [ADDR_W:0] region_end;
        logic [ADDR_W-1:0] deduct;
        int unsigned     left;
        int unsigned     i;
        r.status = ST_OK;
        r.base   = '0;
        r.length = '0;
        r.rtype  = '0;
        case (w.op)
            OP_LOAD:
            begin
                // A full table refuses the load and keeps every figure.
                if (tab_entries >= MAX_ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    tab_base[tab_entries]   = w.base;
                    tab_length[tab_entries] = w.length;
                    tab_type[tab_entries]   = w.rtype;
                    tab_entries++;
                    // A usable region of length zero adds nothing, and the
                    // sums wrap modulo 2^64.
                    if (w.rtype != TYPE_USABLE)
                        unusable_regions++;
                    else
                        usable_bytes += w.length;
                    size_bytes += w.length;
                end
            end
            OP_QUERY:
            begin
                // The region end is taken one bit wider so that a region that
                // reaches past the top of the address space still matches.
                r.status = ST_MISS;
                for (i = 0; i < tab_entries && r.status == ST_MISS; i++) begin
                    region_end = {1'b0, tab_base[i]} + {1'b0, tab_length[i]};
                    if (tab_type[i] == TYPE_USABLE && w.addr >= tab_base[i] &&
                        {1'b0, w.addr} < region_end)
                        r.status = ST_OK;
                end
            end
            OP_SELECT:
            begin
                // Unusable regions are counted in load order from zero.
                left     = w.nidx;
                r.status = ST_MISS;
                for (i = 0; i < tab_entries && r.status == ST_MISS; i++) begin
                    if (tab_type[i] != TYPE_USABLE) begin
                        if (left == 0) begin
                            r.status = ST_OK;
                            r.base   = tab_base[i];
                            r.length = tab_length[i];
                            r.rtype  = tab_type[i];
                        end else begin
                            left--;
                        end
                    end
                end
            end
            default:
            begin
                // Clear empties the table; record_bytes stays as written.
                tab_entries      = 0;
                usable_bytes     = '0;
                size_bytes       = '0;
                unusable_regions = 0;
            end
        endcase
        deduct = 64'(tab_entries) * 64'(record_bytes);
        r.usable_total   = (usable_bytes > deduct) ? usable_bytes - deduct : '0;
        r.total_size     = size_bytes;
        r.unusable_count = FIG_W'(unusable_regions);
        r.entries_used   = FIG_W'(tab_entries);
        return r;
    endfunction

    function automatic void check_field(string name, logic [ADDR_W-1:0] want,
                                        logic [ADDR_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compares the result word now on the master side with one expectation.
    function automatic void check_result(map_result_t want);
        check_field("status",         64'(want.status),         64'(m_tuser));
        check_field("out_base",       want.base,                m_tdata[63:0]);
        check_field("out_length",     want.length,              m_tdata[127:64]);
        check_field("out_type",       64'(want.rtype),          64'(m_tdata[159:128]));
        check_field("usable_total",   want.usable_total,        m_tdata[223:160]);
        check_field("total_size",     want.total_size,          m_tdata[287:224]);
        check_field("unusable_count", 64'(want.unusable_count), 64'(m_tdata[293:288]));
        check_field("entries_used",   64'(want.entries_used),   64'(m_tdata[299:294]));
    endfunction

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned sender_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    // Fields that the operation does not use are random, so that every bit
    // of every field gets toggled.
    function automatic map_word_t filler_word(op_t op, int unsigned idle);
        map_word_t w;
        w.op         = op;
        w.base       = rand64();
        w.length     = rand64();
        w.rtype      = $urandom;
        w.addr       = rand64();
        w.nidx       = NIDX_W'($urandom);
        w.idle_after = idle;
        return w;
    endfunction

    function automatic void push_word(map_word_t w);
        pending_words.push_back(w);
        words_queued++;
    endfunction

    function automatic void push_load(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] length,
                                      logic [RTYPE_W-1:0] rtype, int unsigned idle);
        map_word_t w;
        w        = filler_word(OP_LOAD, idle);
        w.base   = base;
        w.length = length;
        w.rtype  = rtype;
        push_word(w);
    endfunction

    function automatic void push_query(logic [ADDR_W-1:0] addr, int unsigned idle);
        map_word_t w;
        w      = filler_word(OP_QUERY, idle);
        w.addr = addr;
        push_word(w);
    endfunction

    function automatic void push_select(logic [NIDX_W-1:0] nidx, int unsigned idle);
        map_word_t w;
        w      = filler_word(OP_SELECT, idle);
        w.nidx = nidx;
        push_word(w);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_base();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 64'($urandom_range(0, 'hFFFF)) << 12;
            2:       return ADDR_MAX - 64'($urandom_range(0, 'hFFFF));
            default: return rand64();
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_length();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ADDR_MAX;
            2, 3:    return rand64();
            default: return 64'($urandom_range(1, 'h10000));
        endcase
    endfunction

    function automatic logic [RTYPE_W-1:0] pick_type(bit unusable_only);
        logic [RTYPE_W-1:0] t;
        if (unusable_only) begin
            t = $urandom;
            return (t == TYPE_USABLE) ? '0 : t;
        end
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom;
            2:       return '1;
            3:       return RTYPE_W'($urandom_range(2, 5));
            default: return TYPE_USABLE;
        endcase
    endfunction

    // One episode starts from an empty table, loads a number of regions and
    // mixes in queries and selects aimed at what was loaded. A third of the
    // episodes load past a full table. A few words are pure noise.
    task automatic queue_episode();
        logic [ADDR_W-1:0]  ep_base[$];
        logic [ADDR_W-1:0]  ep_len[$];
        logic [ADDR_W-1:0]  b;
        logic [ADDR_W-1:0]  l;
        logic [ADDR_W-1:0]  a;
        logic [RTYPE_W-1:0] t;
        int unsigned        loads_left;
        int unsigned        extra;
        int unsigned        unusable_seen;
        int unsigned        k;
        int unsigned        pick;
        int unsigned        top_index;
        bit                 calm;
        bit                 unusable_only;
        calm          = ($urandom_range(0, 4) == 0);
        unusable_only = ($urandom_range(0, 5) == 0);
        loads_left    = ($urandom_range(0, 2) == 0) ? 34 : $urandom_range(1, 20);
        extra         = $urandom_range(4, 16);
        unusable_seen = 0;
        push_word(filler_word(OP_CLEAR, sender_gap(calm)));
        while (loads_left + extra != 0) begin
            if (loads_left != 0 && (extra == 0 || $urandom_range(0, 2) != 0)) begin
                b = pick_base();
                l = pick_length();
                t = pick_type(unusable_only);
                push_load(b, l, t, sender_gap(calm));
                if (ep_base.size() < MAX_ENTRIES) begin
                    ep_base.push_back(b);
                    ep_len.push_back(l);
                    if (t != TYPE_USABLE)
                        unusable_seen++;
                end
                loads_left--;
            end else begin
                extra--;
                pick = $urandom_range(0, 19);
                if (pick < 11) begin
                    // Most queries land on or just beside a loaded region's bounds.
                    a = rand64();
                    if (ep_base.size() != 0 && pick < 9) begin
                        k = $urandom_range(0, ep_base.size() - 1);
                        case ($urandom_range(0, 3))
                            0:       a = ep_base[k];
                            1:       a = ep_base[k] + ep_len[k] - 1;
                            2:       a = ep_base[k] + ep_len[k];
                            default: a = ep_base[k] - 1;
                        endcase
                    end
                    push_query(a, sender_gap(calm));
                end else if (pick < 17) begin
                    // Mostly within the unusable regions loaded, or up to two past them.
                    top_index = (unusable_seen + 1 > 31) ? 31 : unusable_seen + 1;
                    push_select(NIDX_W'($urandom_range(0, top_index)), sender_gap(calm));
                end else if (pick < 19) begin
                    push_select(NIDX_W'($urandom), sender_gap(calm));
                end else begin
                    push_word(filler_word(op_t'($urandom_range(0, 3)), sender_gap(calm)));
                end
            end
        end
    endtask

    // Waits until every queued word has been taken and every result has come
    // back, then lets the block settle before a register write.
    task automatic wait_until_idle();
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase();
        int unsigned target;
        target = words_queued + PHASE_WORDS;
        while (words_queued < target)
            queue_episode();
        wait_until_idle();
    endtask

    task automatic write_record_bytes(logic [RB_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        record_bytes = value;
        cfg_valid <= 1'b0;
    endtask

    // Sender: offers the queued words in order. A word that is not taken is
    // held unchanged; after a word is taken the sender pauses as drawn.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            send_next = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                expected_results.push_back(region_map_result(offered_word));
                send_idle = offered_word.idle_after;
            end
            if (!send_next) begin
                if (send_idle != 0) begin
                    send_idle--;
                end else if (pending_words.size() != 0) begin
                    offered_word = pending_words.pop_front();
                    s_tdata <= S_TDATA_W'({offered_word.nidx, offered_word.addr,
                                           offered_word.rtype, offered_word.length,
                                           offered_word.base});
                    s_tuser <= offered_word.op;
                    send_next = 1'b1;
                end
            end
            s_tvalid <= send_next;
        end
    end

    // Receiver: checks each result word against the oldest expectation, then
    // stalls as drawn. Now and then it runs a stretch of results with no
    // stalls, and once it holds off for a long time.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h / %h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    check_result(expected_results.pop_front());
                end
                results_seen++;
                if (results_seen == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
                if (calm_left != 0) begin
                    calm_left--;
                    stall_left = 0;
                end else begin
                    stall_left = $urandom_range(0, 14);
                    if ($urandom_range(0, 15) == 0)
                        calm_left = $urandom_range(20, 60);
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: any handshake on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset value of record_bytes. The empty table
        // misses on query and select first.
        push_query(64'h0, sender_gap(0));
        push_select(5'd0, sender_gap(0));
        // A usable region of length zero is stored but never matches.
        push_load(64'h0, 64'h0, TYPE_USABLE, sender_gap(0));
        push_query(64'h0, sender_gap(0));
        // Both bounds of an ordinary region and the addresses just outside.
        push_load(64'h1000, 64'h1000, TYPE_USABLE, sender_gap(0));
        push_query(64'hFFF, sender_gap(0));
        push_query(64'h1000, sender_gap(0));
        push_query(64'h1FFF, sender_gap(0));
        push_query(64'h2000, sender_gap(0));
        // A region whose end lies past the top of the address space.
        push_load(64'hFFFF_FFFF_FFFF_F000, 64'h2000, TYPE_USABLE, sender_gap(0));
        push_query(ADDR_MAX, sender_gap(0));
        push_query(64'hFFFF_FFFF_FFFF_EFFF, sender_gap(0));
        // Unusable regions with extreme fields; the total size wraps.
        push_load(64'h5000, ADDR_MAX, 32'h0, sender_gap(0));
        push_load(ADDR_MAX, 64'h0, 32'hFFFF_FFFF, sender_gap(0));
        push_load(64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 32'h2, sender_gap(0));
        push_select(5'd0, sender_gap(0));
        push_select(5'd2, sender_gap(0));
        push_select(5'd3, sender_gap(0));
        push_select(5'd31, sender_gap(0));
        // The usable sum wraps past 2^64.
        push_load(64'h0, ADDR_MAX, TYPE_USABLE, sender_gap(0));
        push_query(64'h5000, sender_gap(0));
        push_word(filler_word(OP_CLEAR, sender_gap(0)));
        push_query(64'h1000, sender_gap(0));
        push_select(5'd0, sender_gap(0));
        wait_until_idle();

        // Random phases at the largest record size, at a record size of 8 and at a random one.
        write_record_bytes(8'd255);
        run_phase();
        write_record_bytes(8'd8);
        run_phase();
        write_record_bytes(RB_W'($urandom_range(9, 254)));
        run_phase();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
